// ===== rtl/trsg_pkg.sv =====
// Shared types and constants for the triangle span generator.
`default_nettype none

package trsg_pkg;

  localparam int unsigned CoordBits = 12;
  localparam int unsigned ColorBits = 32;

  // command field codes
  localparam logic CmdLoad = 1'b0;
  localparam logic CmdSpan = 1'b1;

  // edge select during a span computation
  localparam logic EdgeShort = 1'b0;
  localparam logic EdgeLong  = 1'b1;

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StDiv,
    StFix,
    StDone
  } trsg_state_e;

endpackage

`default_nettype wire

// ===== rtl/triangle_scanline_span_generator.sv =====
// Triangle span generator: vertex sort, serial edge interpolation, span output.
//
//  channel | signals                                   | dir | moves
//  --------+-------------------------------------------+-----+------------------------
//  in      | in_valid_i/in_ready_o, command_i, a/b/c   | in  | load or span request
//  out     | out_valid_o/out_ready_i, span fields      | out | one span per span request
//
//  A load transaction is taken in the idle state: the vertices are sorted and held at once.
//  A span transaction with a triangle active runs StMul, StDiv and StFix for the short
//  edge and then the long edge, two passes through one restoring divider that yields
//  one quotient bit per cycle, then StDone; with no active triangle it goes to StDone.
//  The input is ready as the result appears; reset clears vertices, row, flag, color.
//  A finished span waits in its own state only while the previous one is still unclaimed.
`default_nettype none

module triangle_scanline_span_generator
  import trsg_pkg::*;
#(
  parameter int unsigned COORD_BITS = CoordBits
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic                  command_i,
  input  wire logic [COORD_BITS-1:0] ax_i,
  input  wire logic [COORD_BITS-1:0] ay_i,
  input  wire logic [COORD_BITS-1:0] bx_i,
  input  wire logic [COORD_BITS-1:0] by_coord_i,
  input  wire logic [COORD_BITS-1:0] cx_i,
  input  wire logic [COORD_BITS-1:0] cy_i,
  input  wire logic [ColorBits-1:0]  fill_color_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic                       span_valid_o,
  output logic [COORD_BITS-1:0]      row_o,
  output logic [COORD_BITS-1:0]      x_left_o,
  output logic [COORD_BITS-1:0]      x_right_o,
  output logic [ColorBits-1:0]       span_color_o,
  output logic                       last_span_o
);

  localparam int unsigned CB   = COORD_BITS;
  localparam int unsigned CntW = $clog2(CB);

  typedef logic [CB-1:0] coord_t;

  trsg_state_e state_q, state_d;

  coord_t             vx_q [3];
  coord_t             vy_q [3];
  coord_t             row_q, row_d;
  logic               active_q, active_d;
  logic [ColorBits-1:0] color_q;

  logic               sel_q, sel_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  coord_t             rem_q, rem_d;
  coord_t             quo_q, quo_d;
  coord_t             xa_q;
  coord_t             den_q;
  logic               neg_q;
  logic               zero_q;
  coord_t             ea_q;
  coord_t             lo_q, hi_q;
  logic               span_q;

  logic               out_valid_q;
  logic               out_span_q, out_last_q;
  coord_t             out_row_q, out_lo_q, out_hi_q;
  logic [ColorBits-1:0] out_color_q;

  logic in_fire, load_fire, span_fire, out_slot, out_load;

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;
  assign load_fire  = in_fire && (command_i == CmdLoad);
  assign span_fire  = in_fire && (command_i == CmdSpan);
  assign out_slot   = !out_valid_q || out_ready_i;
  assign out_load   = (state_q == StDone) && out_slot;

  // sort network on the incoming vertices: exchange (0,1), (0,2), (1,2)
  coord_t sx [3];
  coord_t sy [3];
  always_comb begin
    coord_t tx, ty;
    tx = '0; ty = '0;
    sx[0] = ax_i; sy[0] = ay_i;
    sx[1] = bx_i; sy[1] = by_coord_i;
    sx[2] = cx_i; sy[2] = cy_i;
    if (sy[0] > sy[1]) begin
      tx = sx[0]; ty = sy[0];
      sx[0] = sx[1]; sy[0] = sy[1];
      sx[1] = tx; sy[1] = ty;
    end
    if (sy[0] > sy[2]) begin
      tx = sx[0]; ty = sy[0];
      sx[0] = sx[2]; sy[0] = sy[2];
      sx[2] = tx; sy[2] = ty;
    end
    if (sy[1] > sy[2]) begin
      tx = sx[1]; ty = sy[1];
      sx[1] = sx[2]; sy[1] = sy[2];
      sx[2] = tx; sy[2] = ty;
    end
  end

  // edge operands for the current row
  logic [1:0] ia, ib;
  always_comb begin
    priority if (sel_q == EdgeShort && row_q < vy_q[1]) begin
      ia = 2'd0; ib = 2'd1;
    end else if (sel_q == EdgeShort) begin
      ia = 2'd1; ib = 2'd2;
    end else begin
      ia = 2'd0; ib = 2'd2;
    end
  end

  coord_t        op_xa, op_ya, op_xb, op_yb, op_dy, op_t, op_mag;
  logic [CB:0]   op_dx, op_dx_abs;
  logic [2*CB-1:0] op_prod;
  always_comb begin
    op_xa     = vx_q[ia];
    op_ya     = vy_q[ia];
    op_xb     = vx_q[ib];
    op_yb     = vy_q[ib];
    op_dy     = op_yb - op_ya;
    op_t      = row_q - op_ya;
    op_dx     = {1'b0, op_xb} - {1'b0, op_xa};
    op_dx_abs = op_dx[CB] ? (~op_dx + {{CB{1'b0}}, 1'b1}) : op_dx;
    op_mag    = op_dx_abs[CB-1:0];
    op_prod   = {{CB{1'b0}}, op_mag} * {{CB{1'b0}}, op_t};
  end

  // one restoring division step
  logic [CB:0] div_sh, div_diff;
  logic        div_ge;
  always_comb begin
    div_sh   = {rem_q, quo_q[CB-1]};
    div_diff = div_sh - {1'b0, den_q};
    div_ge   = (div_sh >= {1'b0, den_q});
  end

  // floor correction and final edge x
  coord_t fix_x;
  logic   rem_nz;
  always_comb begin
    rem_nz = (rem_q != '0);
    if (zero_q) begin
      fix_x = xa_q;
    end else if (neg_q) begin
      fix_x = xa_q - quo_q - {{(CB-1){1'b0}}, rem_nz};
    end else begin
      fix_x = xa_q + quo_q;
    end
  end

  logic res_last;
  assign res_last = span_q && (row_q >= vy_q[2]);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (span_fire) state_d = active_q ? StMul : StDone;
      end
      StMul: state_d = StDiv;
      StDiv: begin
        if (cnt_q == CntW'(CB - 1)) state_d = StFix;
      end
      StFix: state_d = (sel_q == EdgeShort) ? StMul : StDone;
      StDone: begin
        if (out_slot) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // datapath control
  always_comb begin
    sel_d    = sel_q;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    row_d    = row_q;
    active_d = active_q;
    unique case (state_q)
      StIdle: begin
        sel_d = EdgeShort;
        if (load_fire) begin
          row_d    = sy[0];
          active_d = 1'b1;
        end
      end
      StMul: begin
        cnt_d = '0;
        rem_d = op_prod[2*CB-1:CB];
        quo_d = op_prod[CB-1:0];
      end
      StDiv: begin
        cnt_d = cnt_q + CntW'(1);
        rem_d = div_ge ? div_diff[CB-1:0] : div_sh[CB-1:0];
        quo_d = {quo_q[CB-2:0], div_ge};
      end
      StFix: sel_d = EdgeLong;
      StDone: begin
        if (out_slot && span_q) begin
          if (res_last) active_d = 1'b0;
          else          row_d    = row_q + coord_t'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      active_q    <= 1'b0;
      row_q       <= '0;
      color_q     <= '0;
      vx_q        <= '{default: '0};
      vy_q        <= '{default: '0};
      sel_q       <= EdgeShort;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      active_q <= active_d;
      row_q    <= row_d;
      sel_q    <= sel_d;
      cnt_q    <= cnt_d;
      if (load_fire) begin
        vx_q    <= sx;
        vy_q    <= sy;
        color_q <= fill_color_i;
      end
      if (out_load)         out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (span_fire) span_q <= active_q;
    if (state_q == StMul) begin
      xa_q   <= op_xa;
      den_q  <= op_dy;
      neg_q  <= op_dx[CB];
      zero_q <= (op_dy == '0);
    end
    if (state_q == StFix) begin
      if (sel_q == EdgeShort) begin
        ea_q <= fix_x;
      end else begin
        lo_q <= (ea_q < fix_x) ? ea_q : fix_x;
        hi_q <= (ea_q < fix_x) ? fix_x : ea_q;
      end
    end
    if (out_load) begin
      out_span_q  <= span_q;
      out_row_q   <= span_q ? row_q : '0;
      out_lo_q    <= span_q ? lo_q : '0;
      out_hi_q    <= span_q ? hi_q : '0;
      out_color_q <= span_q ? color_q : '0;
      out_last_q  <= res_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign span_valid_o = out_span_q;
  assign row_o        = out_row_q;
  assign x_left_o     = out_lo_q;
  assign x_right_o    = out_hi_q;
  assign span_color_o = out_color_q;
  assign last_span_o  = out_last_q;

  a_span_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> x_left_o <= x_right_o)
    else $error("span ends out of order");

  a_empty_span_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !span_valid_o |->
      row_o == '0 && x_left_o == '0 && x_right_o == '0 && span_color_o == '0 && !last_span_o)
    else $error("empty span carries nonzero fields");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StMul |=> state_q == StDiv && cnt_q == '0)
    else $error("divider not started from zero");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && res_last |=> !active_q && out_valid_q && last_span_o)
    else $error("bottom row did not retire the triangle");

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for the triangle span generator.
`default_nettype none

module tb_top;
  import trsg_pkg::*;

  typedef logic [CoordBits-1:0] coord_t;

  typedef struct packed {
    logic                 span_valid;
    coord_t               row;
    coord_t               x_left;
    coord_t               x_right;
    logic [ColorBits-1:0] color;
    logic                 last_span;
  } span_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid;
  logic                 in_ready_o;
  logic                 command;
  coord_t               ax, ay, bx, by_coord, cx, cy;
  logic [ColorBits-1:0] fill_color;
  logic                 out_valid_o;
  logic                 out_ready;
  logic                 span_valid_o;
  coord_t               row_o, x_left_o, x_right_o;
  logic [ColorBits-1:0] span_color_o;
  logic                 last_span_o;

  // shadow of the rasterizer state
  coord_t               tri_x [3];
  coord_t               tri_y [3];
  coord_t               scan_row;
  logic                 tri_active;
  logic [ColorBits-1:0] tri_color;

  span_t pending_spans[$];
  int    mismatches;
  int    items_sent;
  logic  calm_stretch;

  triangle_scanline_span_generator dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .command_i    (command),
    .ax_i         (ax),
    .ay_i         (ay),
    .bx_i         (bx),
    .by_coord_i   (by_coord),
    .cx_i         (cx),
    .cy_i         (cy),
    .fill_color_i (fill_color),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .span_valid_o (span_valid_o),
    .row_o        (row_o),
    .x_left_o     (x_left_o),
    .x_right_o    (x_right_o),
    .span_color_o (span_color_o),
    .last_span_o  (last_span_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

  // floor(xa + (xb-xa)*(y-ya)/(yb-ya)); flat edge gives xa
  function automatic longint edge_x_at(coord_t xa, coord_t ya, coord_t xb, coord_t yb,
                                       coord_t y);
    longint d, n, q;
    d = longint'(yb) - longint'(ya);
    if (d <= 0) return longint'(xa);
    n = (longint'(xb) - longint'(xa)) * (longint'(y) - longint'(ya));
    q = n / d;
    if (n % d != 0 && n < 0) q = q - 1;
    return longint'(xa) + q;
  endfunction

  task automatic order_pair(int i, int j);
    coord_t tx, ty;
    if (tri_y[i] > tri_y[j]) begin
      tx = tri_x[i];
      ty = tri_y[i];
      tri_x[i] = tri_x[j];
      tri_y[i] = tri_y[j];
      tri_x[j] = tx;
      tri_y[j] = ty;
    end
  endtask

  // Advance the shadow rasterizer by one accepted transaction.
  task automatic track_triangle(logic cmd, coord_t pax, coord_t pay, coord_t pbx, coord_t pby,
                                coord_t pcx, coord_t pcy, logic [ColorBits-1:0] color);
    longint ea, eb;
    span_t  s;
    s = '0;
    if (cmd == CmdLoad) begin
      tri_x[0] = pax; tri_y[0] = pay;
      tri_x[1] = pbx; tri_y[1] = pby;
      tri_x[2] = pcx; tri_y[2] = pcy;
      order_pair(0, 1);
      order_pair(0, 2);
      order_pair(1, 2);
      tri_color  = color;
      scan_row   = tri_y[0];
      tri_active = 1'b1;
      return;
    end
    if (tri_active) begin
      if (scan_row < tri_y[1])
        ea = edge_x_at(tri_x[0], tri_y[0], tri_x[1], tri_y[1], scan_row);
      else
        ea = edge_x_at(tri_x[1], tri_y[1], tri_x[2], tri_y[2], scan_row);
      eb = edge_x_at(tri_x[0], tri_y[0], tri_x[2], tri_y[2], scan_row);
      s.span_valid = 1'b1;
      s.row        = scan_row;
      s.x_left     = coord_t'(ea < eb ? ea : eb);
      s.x_right    = coord_t'(ea < eb ? eb : ea);
      s.color      = tri_color;
      s.last_span  = (scan_row >= tri_y[2]);
      if (s.last_span) tri_active = 1'b0;
      else scan_row = scan_row + 1'b1;
    end
    pending_spans.push_back(s);
  endtask

  task automatic send_item(logic cmd, coord_t pax, coord_t pay, coord_t pbx, coord_t pby,
                           coord_t pcx, coord_t pcy, logic [ColorBits-1:0] color);
    int gap;
    gap = calm_stretch ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    ax         <= pax;
    ay         <= pay;
    bx         <= pbx;
    by_coord   <= pby;
    cx         <= pcx;
    cy         <= pcy;
    fill_color <= color;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    track_triangle(cmd, pax, pay, pbx, pby, pcx, pcy, color);
    items_sent++;
  endtask

  task automatic send_load(coord_t pax, coord_t pay, coord_t pbx, coord_t pby,
                           coord_t pcx, coord_t pcy, logic [ColorBits-1:0] color);
    send_item(CmdLoad, pax, pay, pbx, pby, pcx, pcy, color);
  endtask

  // Vertex fields are ignored on a row request; fill them with noise.
  task automatic send_rows(int n);
    repeat (n)
      send_item(CmdSpan, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                coord_t'($urandom), coord_t'($urandom), coord_t'($urandom), $urandom);
  endtask

  function automatic void note_mismatch(string field, longint unsigned want,
                                        longint unsigned got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %0h, actual %0h", field, want, got);
  endfunction

  task automatic check_span();
    span_t want;
    if (pending_spans.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected span transaction: row %0d x %0d..%0d", row_o, x_left_o,
                 x_right_o);
      return;
    end
    want = pending_spans.pop_front();
    if (span_valid_o !== want.span_valid) note_mismatch("span_valid", want.span_valid,
                                                        span_valid_o);
    if (row_o !== want.row) note_mismatch("row", want.row, row_o);
    if (x_left_o !== want.x_left) note_mismatch("x_left", want.x_left, x_left_o);
    if (x_right_o !== want.x_right) note_mismatch("x_right", want.x_right, x_right_o);
    if (span_color_o !== want.color) note_mismatch("span_color", want.color, span_color_o);
    if (last_span_o !== want.last_span) note_mismatch("last_span", want.last_span,
                                                      last_span_o);
  endtask

  // Receiver: stall a random number of cycles before each transaction.
  initial begin : span_receiver
    int stall;
    out_ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = calm_stretch ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      check_span();
    end
  end

  task automatic test_no_triangle();
    send_rows(1);
  endtask

  task automatic test_single_row();
    send_load(12'd5, 12'd7, 12'd100, 12'd7, 12'd50, 12'd7, 32'h0000_0000);
    send_rows(2);
  endtask

  task automatic test_extreme_coords();
    // tall triangle, replaced before its bottom row
    send_load(12'd0, 12'd0, 12'd4095, 12'd4095, 12'd4095, 12'd0, 32'hffff_ffff);
    send_rows(3);
    send_load(12'd4095, 12'd4095, 12'd0, 12'd4093, 12'd4095, 12'd4094, 32'ha5a5_5a5a);
    send_rows(3);
  endtask

  task automatic test_sorting_and_flat_edges();
    send_load(12'd10, 12'd2, 12'd30, 12'd1, 12'd50, 12'd0, 32'h1234_5678);
    send_rows(3);
    // flat top with a tie on y
    send_load(12'd100, 12'd3, 12'd0, 12'd3, 12'd50, 12'd6, 32'h0f0f_0f0f);
    send_rows(4);
    // flat bottom, left edge slopes negative
    send_load(12'd50, 12'd0, 12'd0, 12'd2, 12'd100, 12'd2, 32'h8000_0001);
    send_rows(4);
  endtask

  task automatic test_random_triangles(int count);
    int     goal, h, base, rows, k, j, pick;
    coord_t xs[3], ys[3], t;
    goal = items_sent + count;
    while (items_sent < goal) begin
      if ($urandom_range(0, 7) == 0) calm_stretch = ~calm_stretch;
      if ($urandom_range(0, 9) == 0) begin
        // noise: stray rows, or a full-range load that is cut short
        if ($urandom_range(0, 1) == 0) begin
          send_rows($urandom_range(1, 3));
        end else begin
          send_load(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                    coord_t'($urandom), coord_t'($urandom), coord_t'($urandom), $urandom);
          send_rows($urandom_range(0, 3));
        end
      end else begin
        h = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 80) : $urandom_range(0, 12);
        base = $urandom_range(0, 4095 - h);
        ys[0] = coord_t'(base);
        ys[2] = coord_t'(base + h);
        pick = $urandom_range(0, 5);
        if (pick == 0) ys[1] = ys[0];
        else if (pick == 1) ys[1] = ys[2];
        else ys[1] = coord_t'($urandom_range(base, base + h));
        for (k = 0; k < 3; k++) begin
          if ($urandom_range(0, 1) == 0) xs[k] = coord_t'($urandom);
          else xs[k] = coord_t'($urandom_range(0, 4000) + $urandom_range(0, 95));
        end
        // shuffle vertex order so every sort path is taken
        for (k = 0; k < 3; k++) begin
          j = $urandom_range(0, 2);
          t = xs[k]; xs[k] = xs[j]; xs[j] = t;
          t = ys[k]; ys[k] = ys[j]; ys[j] = t;
        end
        pick = $urandom_range(0, 9);
        if (pick == 0) rows = $urandom_range(0, h);
        else if (pick == 1) rows = h + 1 + $urandom_range(1, 2);
        else rows = h + 1;
        send_load(xs[0], ys[0], xs[1], ys[1], xs[2], ys[2], $urandom);
        send_rows(rows);
      end
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid     = 1'b0;
    command      = CmdLoad;
    ax           = '0;
    ay           = '0;
    bx           = '0;
    by_coord     = '0;
    cx           = '0;
    cy           = '0;
    fill_color   = '0;
    mismatches   = 0;
    items_sent   = 0;
    calm_stretch = 1'b0;
    tri_x        = '{default: '0};
    tri_y        = '{default: '0};
    scan_row     = '0;
    tri_active   = 1'b0;
    tri_color    = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_no_triangle();
    test_single_row();
    test_extreme_coords();
    test_sorting_and_flat_edges();
    test_random_triangles(900);

    in_valid <= 1'b0;
    while (pending_spans.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && pending_spans.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
